/* hw/rtl/bmd_pkg.sv */
// ----------------------------------------------------------------------------
// bmd_pkg
// shared types and sizes of the block mean downsampler
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 20;
    localparam int COLS      = 1024;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int BS_W      = 7;
    localparam int OFS_W     = 6;
    localparam int W_W       = 11;
    localparam int H_W       = 13;
    localparam int CNT_W     = 13;
    localparam int Q_W       = 8;
    localparam int QI_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam int OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd2;

    localparam logic [BS_W-1:0] MAX_SIDE = 7'd64;
    localparam logic [W_W-1:0]  MAX_WID  = 11'd1024;
    localparam logic [H_W-1:0]  MAX_HGT  = 13'd4096;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_DIV,
        S_PUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic add;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic block_end;
        logic div_last;
        logic out_full;
    } t_status;

endpackage

/* hw/rtl/bmd_ram.sv */
// ----------------------------------------------------------------------------
// bmd_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/bmd_ctrl.sv */
// ----------------------------------------------------------------------------
// bmd_ctrl
// sequencer: clearing pass, accumulate, divide, hand result to output
// ----------------------------------------------------------------------------
module bmd_ctrl import bmd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_restart,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_status.block_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_PUT;
            end
            S_PUT: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // a write to block size, width or height restarts the frame
        if (i_restart) begin
            n_state    = S_CLEAR;
            o_cmd      = '0;
            o_s_tready = 1'b0;
        end
    end
endmodule

/* hw/rtl/bmd_dpath.sv */
// ----------------------------------------------------------------------------
// bmd_dpath
// position counters, column accumulators, restoring divider, output register
// ----------------------------------------------------------------------------
module bmd_dpath import bmd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_restart,
    input  logic [PIX_W-1:0]     i_pixel,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,
    output logic                 o_m_tlast
);
    logic [BS_W-1:0] r_bs;
    logic [W_W-1:0]  r_w;
    logic [H_W-1:0]  r_h;
    logic [BS_W-1:0] bs_e;
    logic [W_W-1:0]  w_e;
    logic [H_W-1:0]  h_e;

    logic [COL_W-1:0] r_x, r_bc;
    logic [ROW_W-1:0] r_y, r_br;
    logic [OFS_W-1:0] r_xo, r_yo;
    logic             x_last, y_last, xo_last, yo_last;

    logic [PIX_W-1:0] r_pix;
    logic [COL_W-1:0] r_slot;
    logic [ROW_W-1:0] r_brow;
    logic             r_bend, r_flast;
    logic [CNT_W-1:0] r_cnt;
    logic [2*BS_W-1:0] prod;

    logic [SUM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;
    logic [QI_W-1:0]  r_qi;
    logic [SUM_W-1:0] trial;

    logic [COL_W-1:0] r_clr_cnt;
    logic [SUM_W-1:0] rdata, sum;
    logic             ram_we;
    logic [COL_W-1:0] ram_waddr;
    logic [SUM_W-1:0] ram_wdata;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    assign o_restart = i_cfg_we && (i_cfg_idx == REG_BLOCK_SIZE || i_cfg_idx == REG_WIDTH
                                    || i_cfg_idx == REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= 7'd8;
            r_w  <= 11'd640;
            r_h  <= 13'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_SIZE: r_bs <= i_cfg_data[BS_W-1:0];
                REG_WIDTH:      r_w  <= i_cfg_data[W_W-1:0];
                REG_HEIGHT:     r_h  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        bs_e = (r_bs == '0) ? BS_W'(1) : ((r_bs > MAX_SIDE) ? MAX_SIDE : r_bs);
        w_e  = (r_w == '0) ? W_W'(1) : ((r_w > MAX_WID) ? MAX_WID : r_w);
        h_e  = (r_h == '0) ? H_W'(1) : ((r_h > MAX_HGT) ? MAX_HGT : r_h);
    end

    assign x_last  = ({1'b0, r_x} + W_W'(1)) == w_e;
    assign y_last  = ({1'b0, r_y} + H_W'(1)) == h_e;
    assign xo_last = ({1'b0, r_xo} + BS_W'(1)) == bs_e;
    assign yo_last = ({1'b0, r_yo} + BS_W'(1)) == bs_e;
    assign prod    = ({1'b0, r_xo} + BS_W'(1)) * ({1'b0, r_yo} + BS_W'(1));

    // raster position, kept as block index plus offset inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_restart) begin
            r_x  <= '0;
            r_y  <= '0;
            r_xo <= '0;
            r_yo <= '0;
            r_bc <= '0;
            r_br <= '0;
        end else if (i_cmd.accept) begin
            if (x_last) begin
                r_x  <= '0;
                r_xo <= '0;
                r_bc <= '0;
                if (y_last) begin
                    r_y  <= '0;
                    r_yo <= '0;
                    r_br <= '0;
                end else begin
                    r_y <= r_y + ROW_W'(1);
                    if (yo_last) begin
                        r_yo <= '0;
                        r_br <= r_br + ROW_W'(1);
                    end else begin
                        r_yo <= r_yo + OFS_W'(1);
                    end
                end
            end else begin
                r_x <= r_x + COL_W'(1);
                if (xo_last) begin
                    r_xo <= '0;
                    r_bc <= r_bc + COL_W'(1);
                end else begin
                    r_xo <= r_xo + OFS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix   <= i_pixel;
            r_slot  <= r_bc;
            r_brow  <= r_br;
            r_bend  <= (x_last || xo_last) && (y_last || yo_last);
            r_flast <= x_last && y_last;
            r_cnt   <= prod[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_restart) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + COL_W'(1);
        end
    end

    assign sum = rdata + SUM_W'(r_pix);

    always_comb begin
        ram_we    = i_cmd.clr || i_cmd.add;
        ram_waddr = i_cmd.clr ? r_clr_cnt : r_slot;
        ram_wdata = (i_cmd.clr || r_bend) ? '0 : sum;
    end

    bmd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (COLS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_bc),
        .o_rdata (rdata)
    );

    // restoring division, one quotient bit a cycle, msb first
    assign trial = SUM_W'(r_den) << r_qi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_rem <= sum;
            r_den <= r_cnt;
            r_q   <= '0;
            r_qi  <= QI_W'(Q_W - 1);
        end else if (i_cmd.div_step) begin
            if (r_rem >= trial) begin
                r_rem      <= r_rem - trial;
                r_q[r_qi] <= 1'b1;
            end
            r_qi <= r_qi - QI_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_q, r_slot, r_brow};
            r_out_last <= r_flast;
        end
    end

    always_comb begin
        o_status.clr_done  = &r_clr_cnt;
        o_status.block_end = r_bend;
        o_status.div_last  = r_qi == '0;
        o_status.out_full  = r_out_valid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
endmodule

/* hw/rtl/block_mean_downsampler_core.sv */
// ----------------------------------------------------------------------------
// block_mean_downsampler_core
// block average pooling of a raster grayscale stream, one mean per block
// ----------------------------------------------------------------------------
//  channel   dir  signals                       contents
//  s (pixel) in   i_s_tvalid/o_s_tready/tdata   tdata[7:0] pixel
//  m (block) out  o_m_tvalid/i_m_tready/tdata   row[11:0] col[21:12] mean[29:22]
//                 o_m_tlast                     last block of the frame
//  cfg       in   i_cfg_we/i_cfg_idx/i_cfg_data block_size, image_width, height
//
//  a pixel is read from the accumulator ram when taken, then added and written
//  back; a pixel that closes a block then passes through the divider and the
//  output load. after reset and after a write to block_size, image_width or
//  height, a clearing pass writes all 1024 ram entries before pixels are taken.
//  a completed block waits in the output register while the next pixels
//  are taken; only a second block end stalls until it is taken.
// ----------------------------------------------------------------------------
module block_mean_downsampler_core import bmd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PIX_W-1:0]     i_s_tdata,   // [7:0] pixel
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,   // block_row, block_col, mean, zero fill
    output logic                 o_m_tlast
);
    t_cmd    cmd;
    t_status status;
    logic    restart;

    bmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bmd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_restart  (restart),
        .i_pixel    (i_s_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );
endmodule
